FILE: rtl/afd8_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afd8_pkg
// Shared constants, register codes, tap weights and pipeline side-band type
// for the eighth-order 2D acoustic wave stencil step core.
// ---------------------------------------------------------------------------
package afd8_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int RADIUS     = 4;
	localparam int LINES      = 2 * RADIUS;
	localparam int TAPS       = 2 * RADIUS + 1;
	localparam int COL_BITS   = 10;
	localparam int ROW_BITS   = 12;
	localparam int W_BITS     = 11;
	localparam int H_BITS     = 13;
	localparam int FIELD_BITS = 32;
	localparam int VEL_BITS   = 16;
	localparam int COEF_BITS  = 48;
	localparam int LAP_BITS   = 48;
	localparam int TAP_BITS   = 16;

	// input word kinds carried on tuser
	localparam logic CMD_CELL  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_COEF_ROW    = 3'd0,
		REG_COEF_COL    = 3'd1,
		REG_GRID_WIDTH  = 3'd2,
		REG_GRID_HEIGHT = 3'd3,
		REG_SRC_ROW     = 3'd4,
		REG_SRC_COL     = 3'd5
	} afd8_reg_t;

	// side-band travelling with each result through the update pipeline
	typedef struct packed {
		logic                           interior;
		logic                           last;
		logic signed [FIELD_BITS-1:0]   cur;
		logic signed [FIELD_BITS-1:0]   prev;
	} afd8_side_t;

	// eighth-order second-derivative weights, scaled by 5040
	function automatic logic signed [TAP_BITS-1:0] tap_weight(input logic [3:0] k);
		logic signed [TAP_BITS-1:0] w;
		unique case (k)
			4'd0, 4'd8: w = -16'sd9;
			4'd1, 4'd7: w = 16'sd128;
			4'd2, 4'd6: w = -16'sd1008;
			4'd3, 4'd5: w = 16'sd8064;
			4'd4:       w = -16'sd14350;
			default:    w = 16'sd0;
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/acoustic_wave_fd8_stencil_step_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acoustic_wave_fd8_stencil_step_core
// One time step of the 2D acoustic wave equation with an eighth-order
// stencil, streamed in raster order through line buffers and a tap chain.
// ---------------------------------------------------------------------------
//  port group   direction  word
//  s_*          in         cell or drain command
//  m_*          out        next field, current field with source, frame end
//  apb          in/out     coefficients, grid size, source position
//
//  One input word is taken per clock while the output is not stalled; each
//  result passes the registered line-buffer read, the laplacian stage and the
//  five-stage multiply pipeline.  The whole pipeline holds while a result
//  waits on m_tready.  Reset clears counters and valid flags and loads the
//  configuration registers; line buffers are not cleared and need no sweep.
// ---------------------------------------------------------------------------
module acoustic_wave_fd8_stencil_step_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,  // cur_value, prev_value, velocity, source_amp
	input  logic [0:0]    s_tuser,  // command
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata,  // next_value, cur_with_source
	output logic          m_tlast,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	localparam int CB = afd8_pkg::COL_BITS;
	localparam int RB = afd8_pkg::ROW_BITS;
	localparam int WB = afd8_pkg::W_BITS;
	localparam int HB = afd8_pkg::H_BITS;

	// configuration registers
	logic [47:0]   coef_row_q, coef_col_q;
	logic [WB-1:0] grid_width_q;
	logic [HB-1:0] grid_height_q;
	logic [RB-1:0] src_row_q;
	logic [CB-1:0] src_col_q;
	logic          cfg_we;
	logic          size_we;
	afd8_pkg::afd8_reg_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = afd8_pkg::afd8_reg_t'(paddr[5:3]);
	assign size_we = cfg_we && (cfg_idx == afd8_pkg::REG_GRID_WIDTH
	                         || cfg_idx == afd8_pkg::REG_GRID_HEIGHT);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_row_q    <= '0;
			coef_col_q    <= '0;
			grid_width_q  <= WB'(9);
			grid_height_q <= HB'(9);
			src_row_q     <= '0;
			src_col_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				afd8_pkg::REG_COEF_ROW:    coef_row_q    <= pwdata[47:0];
				afd8_pkg::REG_COEF_COL:    coef_col_q    <= pwdata[47:0];
				afd8_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[WB-1:0];
				afd8_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[HB-1:0];
				afd8_pkg::REG_SRC_ROW:     src_row_q     <= pwdata[RB-1:0];
				afd8_pkg::REG_SRC_COL:     src_col_q     <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (cfg_idx)
			afd8_pkg::REG_COEF_ROW:    prdata = {16'd0, coef_row_q};
			afd8_pkg::REG_COEF_COL:    prdata = {16'd0, coef_col_q};
			afd8_pkg::REG_GRID_WIDTH:  prdata = {53'd0, grid_width_q};
			afd8_pkg::REG_GRID_HEIGHT: prdata = {51'd0, grid_height_q};
			afd8_pkg::REG_SRC_ROW:     prdata = {52'd0, src_row_q};
			afd8_pkg::REG_SRC_COL:     prdata = {54'd0, src_col_q};
			default:                   prdata = '0;
		endcase
	end

	// effective grid size
	logic [WB-1:0] w_eff;
	logic [HB-1:0] h_eff;

	always_comb begin
		if (grid_width_q < WB'(afd8_pkg::LINES + 1)) begin
			w_eff = WB'(afd8_pkg::LINES + 1);
		end else if (grid_width_q > WB'(afd8_pkg::MAX_WIDTH)) begin
			w_eff = WB'(afd8_pkg::MAX_WIDTH);
		end else begin
			w_eff = grid_width_q;
		end
		if (grid_height_q < HB'(afd8_pkg::LINES + 1)) begin
			h_eff = HB'(afd8_pkg::LINES + 1);
		end else if (grid_height_q > HB'(afd8_pkg::MAX_HEIGHT)) begin
			h_eff = HB'(afd8_pkg::MAX_HEIGHT);
		end else begin
			h_eff = grid_height_q;
		end
	end

	// input word fields
	logic               en, accept, is_drain, cell_acc;
	logic signed [31:0] cur_in, prev_in, amp_in, cur_eff;
	logic [15:0]        vel_in;
	logic signed [32:0] src_sum;

	assign cur_in   = s_tdata[31:0];
	assign prev_in  = s_tdata[63:32];
	assign vel_in   = s_tdata[79:64];
	assign amp_in   = s_tdata[111:80];
	assign is_drain = (s_tuser[0] == afd8_pkg::CMD_DRAIN);

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;
	assign cell_acc = accept && !is_drain;

	// position counters
	logic [CB-1:0] in_col_q, out_col_q;
	logic [RB-1:0] in_row_q, out_row_q;

	// source injection with saturation
	always_comb begin
		src_sum = $signed({cur_in[31], cur_in}) + $signed({amp_in[31], amp_in});
		cur_eff = cur_in;
		if (in_row_q == src_row_q && in_col_q == src_col_q) begin
			if (src_sum > 33'sd2147483647) begin
				cur_eff = 32'sh7FFF_FFFF;
			end else if (src_sum < -33'sd2147483648) begin
				cur_eff = 32'sh8000_0000;
			end else begin
				cur_eff = src_sum[31:0];
			end
		end
	end

	// emission decision and the cell it addresses
	logic          frame_start, drain_ok, emit;
	logic [RB-1:0] er;
	logic [CB-1:0] ec;
	logic          interior, last_cell;
	logic [WB-1:0] in_col_inc, out_col_inc;
	logic [HB-1:0] in_row_inc, out_row_inc;

	assign frame_start = (in_row_q == '0) && (in_col_q == '0);
	assign drain_ok    = frame_start && (out_row_q != '0)
	                  && ({1'b0, out_row_q} < h_eff) && ({1'b0, out_col_q} < w_eff);
	assign emit        = accept && (is_drain ? drain_ok
	                                         : (in_row_q >= RB'(afd8_pkg::RADIUS)));
	assign er          = is_drain ? out_row_q : (in_row_q - RB'(afd8_pkg::RADIUS));
	assign ec          = is_drain ? out_col_q : in_col_q;

	assign interior  = (er >= RB'(afd8_pkg::RADIUS))
	                && (({1'b0, er} + HB'(afd8_pkg::RADIUS)) < h_eff)
	                && (ec >= CB'(afd8_pkg::RADIUS))
	                && (({1'b0, ec} + WB'(afd8_pkg::RADIUS)) < w_eff)
	                && !is_drain;
	assign last_cell = ({1'b0, er} == (h_eff - HB'(1))) && ({1'b0, ec} == (w_eff - WB'(1)));

	assign in_col_inc  = {1'b0, in_col_q} + WB'(1);
	assign in_row_inc  = {1'b0, in_row_q} + HB'(1);
	assign out_col_inc = {1'b0, out_col_q} + WB'(1);
	assign out_row_inc = {1'b0, out_row_q} + HB'(1);

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (size_we) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (!is_drain) begin
				if (in_col_inc >= w_eff) begin
					in_col_q <= '0;
					in_row_q <= (in_row_inc >= h_eff) ? '0 : in_row_inc[RB-1:0];
				end else begin
					in_col_q <= in_col_inc[CB-1:0];
				end
			end
			if (!is_drain && frame_start) begin
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (emit) begin
				if (out_col_inc >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= (out_row_inc >= h_eff) ? '0 : out_row_inc[RB-1:0];
				end else begin
					out_col_q <= out_col_inc[CB-1:0];
				end
			end
		end
	end

	// line buffers of current values, one per row slot
	logic [31:0] bank_rd [afd8_pkg::LINES];

	for (genvar b = 0; b < afd8_pkg::LINES; b++) begin : g_line
		afd8_ram #(.ADDR_BITS(CB), .DATA_BITS(32)) u_line (
			.clk   (clk),
			.we    (cell_acc && (in_row_q[2:0] == 3'(b))),
			.waddr (in_col_q),
			.wdata (cur_eff),
			.re    (en),
			.raddr (ec),
			.rdata (bank_rd[b])
		);
	end

	// previous-field and velocity row delays
	logic [31:0] prev_rd;
	logic [15:0] vel_rd;
	logic [47:0] lapc_rd;

	afd8_ram #(.ADDR_BITS(CB + 2), .DATA_BITS(32)) u_prev (
		.clk   (clk),
		.we    (cell_acc),
		.waddr ({in_row_q[1:0], in_col_q}),
		.wdata (prev_in),
		.re    (en),
		.raddr ({er[1:0], ec}),
		.rdata (prev_rd)
	);

	afd8_ram #(.ADDR_BITS(CB + 2), .DATA_BITS(16)) u_vel (
		.clk   (clk),
		.we    (cell_acc),
		.waddr ({in_row_q[1:0], in_col_q}),
		.wdata (vel_in),
		.re    (en),
		.raddr ({er[1:0], ec}),
		.rdata (vel_rd)
	);

	// along-row tap chain of incoming current values
	logic signed [31:0] chain_val  [afd8_pkg::TAPS];
	logic signed [47:0] chain_prod [afd8_pkg::TAPS];
	logic signed [47:0] lapc_sum;
	logic               lapc_we_q;
	logic [CB+1:0]      lapc_addr_q;

	for (genvar k = 0; k < afd8_pkg::TAPS; k++) begin : g_cell
		afd8_tap_cell u_cell (
			.clk    (clk),
			.shift  (cell_acc),
			.din    ((k == 0) ? cur_eff : chain_val[(k == 0) ? 0 : k - 1]),
			.weight (afd8_pkg::tap_weight(4'(k))),
			.dout   (chain_val[k]),
			.prod   (chain_prod[k])
		);
	end

	always_comb begin
		lapc_sum = '0;
		for (int k = 0; k < afd8_pkg::TAPS; k++) begin
			lapc_sum = lapc_sum + chain_prod[k];
		end
	end

	// column laplacian is written in the cycle after its last tap arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lapc_we_q <= 1'b0;
		end else begin
			lapc_we_q <= cell_acc && (in_col_q >= CB'(afd8_pkg::LINES));
		end
	end

	always_ff @(posedge clk) begin
		lapc_addr_q <= {in_row_q[1:0], in_col_q - CB'(afd8_pkg::RADIUS)};
	end

	afd8_ram #(.ADDR_BITS(CB + 2), .DATA_BITS(48)) u_lapc (
		.clk   (clk),
		.we    (lapc_we_q),
		.waddr (lapc_addr_q),
		.wdata (lapc_sum),
		.re    (en),
		.raddr ({er[1:0], ec}),
		.rdata (lapc_rd)
	);

	// stage 1: aligned with line-buffer read data
	logic               v_s1, interior_s1, last_s1;
	logic [2:0]         rot_s1, ctr_s1;
	logic signed [31:0] bot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			interior_s1 <= interior;
			last_s1     <= last_cell;
			rot_s1      <= in_row_q[2:0];
			ctr_s1      <= er[2:0];
			bot_s1      <= cur_eff;
		end
	end

	// row laplacian over the eight buffered rows and the incoming one
	logic signed [47:0] lapr_sum;
	logic signed [31:0] tap_val;
	logic [2:0]         slot;

	always_comb begin
		lapr_sum = '0;
		tap_val  = '0;
		slot     = '0;
		for (int k = 0; k < afd8_pkg::TAPS; k++) begin
			slot    = rot_s1 + 3'(k);
			tap_val = (k == afd8_pkg::LINES) ? bot_s1 : $signed(bank_rd[slot]);
			lapr_sum = lapr_sum + afd8_pkg::tap_weight(4'(k)) * tap_val;
		end
	end

	// stage 2: laplacians and side-band into the update pipeline
	logic                 v_s2;
	afd8_pkg::afd8_side_t side_s2;
	logic signed [47:0]   lapr_s2, lapc_s2;
	logic [15:0]          vel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.interior <= interior_s1;
			side_s2.last     <= last_s1;
			side_s2.cur      <= bank_rd[ctr_s1];
			side_s2.prev     <= prev_rd;
			lapr_s2          <= lapr_sum;
			lapc_s2          <= lapc_rd;
			vel_s2           <= vel_rd;
		end
	end

	// multiply and update pipeline with output register
	logic [31:0] next_value, cur_with_source;

	afd8_update u_update (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (v_s2),
		.in_side         (side_s2),
		.lap_row         (lapr_s2),
		.lap_col         (lapc_s2),
		.vel             (vel_s2),
		.coef_row        (coef_row_q),
		.coef_col        (coef_col_q),
		.out_valid       (m_tvalid),
		.next_value      (next_value),
		.cur_with_source (cur_with_source),
		.last_of_frame   (m_tlast)
	);

	assign m_tdata = {cur_with_source, next_value};

endmodule

FILE: rtl/afd8_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afd8_ram
// Simple dual-port RAM, one write and one registered read port; a read at
// the address being written returns the old word.
// ---------------------------------------------------------------------------
module afd8_ram #(
	parameter int ADDR_BITS = 10,
	parameter int DATA_BITS = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	// write and read-old access
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/afd8_tap_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afd8_tap_cell
// One cell of the along-row stencil chain: holds one field value, passes it
// to its neighbour on each shift and offers it weighted by its tap.
// ---------------------------------------------------------------------------
module afd8_tap_cell (
	input  logic                                  clk,
	input  logic                                  shift,
	input  logic signed [afd8_pkg::FIELD_BITS-1:0] din,
	input  logic signed [afd8_pkg::TAP_BITS-1:0]   weight,
	output logic signed [afd8_pkg::FIELD_BITS-1:0] dout,
	output logic signed [afd8_pkg::LAP_BITS-1:0]   prod
);

	logic signed [afd8_pkg::FIELD_BITS-1:0] value_q;

	// value register
	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= din;
		end
	end

	assign dout = value_q;
	// constant-weight product
	assign prod = value_q * weight;

endmodule

FILE: rtl/afd8_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afd8_update
// Five-stage arithmetic pipeline: laplacians times coefficients, times
// velocity squared, scaling by 2^-56, leapfrog update and saturation.
// ---------------------------------------------------------------------------
module afd8_update (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  afd8_pkg::afd8_side_t                   in_side,
	input  logic signed [afd8_pkg::LAP_BITS-1:0]   lap_row,
	input  logic signed [afd8_pkg::LAP_BITS-1:0]   lap_col,
	input  logic [afd8_pkg::VEL_BITS-1:0]          vel,
	input  logic [afd8_pkg::COEF_BITS-1:0]         coef_row,
	input  logic [afd8_pkg::COEF_BITS-1:0]         coef_col,
	output logic                                   out_valid,
	output logic [afd8_pkg::FIELD_BITS-1:0]        next_value,
	output logic [afd8_pkg::FIELD_BITS-1:0]        cur_with_source,
	output logic                                   last_of_frame
);

	localparam logic signed [74:0] D_MAX = 75'sd1 <<< 50;
	localparam logic signed [74:0] D_MIN = -(75'sd1 <<< 50);
	localparam logic signed [53:0] F_MAX = 54'sd2147483647;
	localparam logic signed [53:0] F_MIN = -54'sd2147483648;

	logic                 v_s1, v_s2, v_s3, v_s4, valid_q;
	afd8_pkg::afd8_side_t side_s1, side_s2, side_s3, side_s4;
	logic signed [64:0]   prr_s1 [3];
	logic signed [64:0]   pcc_s1 [3];
	logic [31:0]          v2_s1, v2_s2;
	logic signed [97:0]   sum_s2;
	logic [63:0]          q0_s3, q1_s3;
	logic signed [66:0]   q2_s3;
	logic signed [130:0]  p_s4;
	logic [31:0]          next_q, cur_q;
	logic                 last_q;

	logic signed [16:0]   crow [3];
	logic signed [16:0]   ccol [3];
	logic signed [97:0]   sum_d;
	logic signed [130:0]  p_d;
	logic signed [74:0]   d_full;
	logic signed [51:0]   d_clamp;
	logic signed [53:0]   t_sum;
	logic [31:0]          t_sat;

	// coefficient slices, 16 bits each
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			crow[j] = $signed({1'b0, coef_row[16*j +: 16]});
			ccol[j] = $signed({1'b0, coef_col[16*j +: 16]});
		end
	end

	// recombine coefficient partial products
	always_comb begin
		sum_d = $signed({{33{prr_s1[0][64]}}, prr_s1[0]})
		      + $signed({{17{prr_s1[1][64]}}, prr_s1[1], 16'd0})
		      + $signed({prr_s1[2][64], prr_s1[2], 32'd0})
		      + $signed({{33{pcc_s1[0][64]}}, pcc_s1[0]})
		      + $signed({{17{pcc_s1[1][64]}}, pcc_s1[1], 16'd0})
		      + $signed({pcc_s1[2][64], pcc_s1[2], 32'd0});
	end

	// recombine velocity partial products
	always_comb begin
		p_d = $signed({q2_s3, 64'd0}) + $signed({35'd0, q1_s3, 32'd0})
		    + $signed({67'd0, q0_s3});
	end

	// scale, clamp, leapfrog update, saturate
	always_comb begin
		d_full = p_s4[130:56];
		if (d_full > D_MAX) begin
			d_clamp = D_MAX[51:0];
		end else if (d_full < D_MIN) begin
			d_clamp = D_MIN[51:0];
		end else begin
			d_clamp = d_full[51:0];
		end
		t_sum = $signed({{2{d_clamp[51]}}, d_clamp})
		      + $signed({{21{side_s4.cur[31]}}, side_s4.cur, 1'b0})
		      - $signed({{22{side_s4.prev[31]}}, side_s4.prev});
		if (t_sum > F_MAX) begin
			t_sat = 32'h7FFF_FFFF;
		end else if (t_sum < F_MIN) begin
			t_sat = 32'h8000_0000;
		end else begin
			t_sat = t_sum[31:0];
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			valid_q <= v_s4;
		end
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				prr_s1[j] <= lap_row * crow[j];
				pcc_s1[j] <= lap_col * ccol[j];
			end
			v2_s1   <= vel * vel;
			side_s1 <= in_side;

			sum_s2  <= sum_d;
			v2_s2   <= v2_s1;
			side_s2 <= side_s1;

			q0_s3   <= sum_s2[31:0] * v2_s2;
			q1_s3   <= sum_s2[63:32] * v2_s2;
			q2_s3   <= $signed(sum_s2[97:64]) * $signed({1'b0, v2_s2});
			side_s3 <= side_s2;

			p_s4    <= p_d;
			side_s4 <= side_s3;

			next_q  <= side_s4.interior ? t_sat : side_s4.prev;
			cur_q   <= side_s4.cur;
			last_q  <= side_s4.last;
		end
	end

	assign out_valid       = valid_q;
	assign next_value      = next_q;
	assign cur_with_source = cur_q;
	assign last_of_frame   = last_q;

endmodule
